[rtl/cdzf_pkg.sv]
// Shared types, operation codes and constants of the camera dead-zone follow block.
package cdzf_pkg;

   localparam int POS_W   = 32;
   localparam int MAG_W   = 44;
   localparam int TMP_W   = 49;
   localparam int PC_W    = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [15:0] MIN_ZOOM = 16'd205;
   localparam logic [16:0] LERP_ONE = 17'd65536;
   localparam int OFF_SHIFT = 28;
   localparam int RAD_SHIFT = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LERP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_Y  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd7;

   localparam int OP_W = 6;
   localparam logic [OP_W-1:0] OP_NOP      = 6'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 6'd1;
   localparam logic [OP_W-1:0] OP_SET      = 6'd2;
   localparam logic [OP_W-1:0] OP_DIV_OFFX = 6'd3;
   localparam logic [OP_W-1:0] OP_GET_OFFX = 6'd4;
   localparam logic [OP_W-1:0] OP_DIV_OFFY = 6'd5;
   localparam logic [OP_W-1:0] OP_GET_OFFY = 6'd6;
   localparam logic [OP_W-1:0] OP_DIV_R    = 6'd7;
   localparam logic [OP_W-1:0] OP_GET_R    = 6'd8;
   localparam logic [OP_W-1:0] OP_DELTA    = 6'd9;
   localparam logic [OP_W-1:0] OP_MUL_DXH  = 6'd10;
   localparam logic [OP_W-1:0] OP_DIV_SX   = 6'd11;
   localparam logic [OP_W-1:0] OP_GET_SX   = 6'd12;
   localparam logic [OP_W-1:0] OP_MUL_AX2  = 6'd13;
   localparam logic [OP_W-1:0] OP_MUL_AY2  = 6'd14;
   localparam logic [OP_W-1:0] OP_MUL_R2   = 6'd15;
   localparam logic [OP_W-1:0] OP_SQRT     = 6'd16;
   localparam logic [OP_W-1:0] OP_GET_DIST = 6'd17;
   localparam logic [OP_W-1:0] OP_MUL_AXE  = 6'd18;
   localparam logic [OP_W-1:0] OP_DIV_Q1   = 6'd19;
   localparam logic [OP_W-1:0] OP_MUL_QW   = 6'd20;
   localparam logic [OP_W-1:0] OP_DIV_MX   = 6'd21;
   localparam logic [OP_W-1:0] OP_GET_MX   = 6'd22;
   localparam logic [OP_W-1:0] OP_MUL_AYE  = 6'd23;
   localparam logic [OP_W-1:0] OP_DIV_MY   = 6'd24;
   localparam logic [OP_W-1:0] OP_GET_MY   = 6'd25;
   localparam logic [OP_W-1:0] OP_ZERO_M   = 6'd26;
   localparam logic [OP_W-1:0] OP_MUL_RW   = 6'd27;
   localparam logic [OP_W-1:0] OP_MUL_HZ   = 6'd28;
   localparam logic [OP_W-1:0] OP_DIV_HX   = 6'd29;
   localparam logic [OP_W-1:0] OP_GET_RECT = 6'd30;
   localparam logic [OP_W-1:0] OP_MUL_LXL  = 6'd31;
   localparam logic [OP_W-1:0] OP_MUL_LXH  = 6'd32;
   localparam logic [OP_W-1:0] OP_GET_LX   = 6'd33;
   localparam logic [OP_W-1:0] OP_MUL_LYL  = 6'd34;
   localparam logic [OP_W-1:0] OP_MUL_LYH  = 6'd35;
   localparam logic [OP_W-1:0] OP_GET_LY   = 6'd36;
   localparam logic [OP_W-1:0] OP_UPDATE   = 6'd37;
   localparam logic [OP_W-1:0] OP_PUBLISH  = 6'd38;

   typedef struct packed {
      logic                   mode;
      logic [15:0]            zoom;
      logic [15:0]            radius;
      logic [16:0]            lerp;
      logic signed [PC_W-1:0] pcx;
      logic signed [PC_W-1:0] pcy;
      logic [10:0]            width;
      logic [10:0]            height;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic unit_done;
      logic outside;
   } status_type;

endpackage

[rtl/camera_dead_zone_follow.sv]
// Top level of the camera dead-zone follow block: register file, sequencer and datapath.
//
//  Channel  Direction  Handshake          Word
//  req_     in         valid / stall      operation, target_x, target_y
//  rsp_     out        valid / stall      camera_x, camera_y, moved
//  csr_     in         valid / ready      index (0..7), data
//
// A set-position word passes through the load, set and publish steps before its
// result word is valid. A follow word is dominated by the shared bit-serial divider:
// four divisions in rectangle mode and up to seven divisions plus a square root in
// ellipse mode. Reset is synchronous and returns the camera to the origin and the
// configuration registers to their defaults. A new word is taken while
// the previous result still waits in the output register; only a finished result
// that finds the output still stalled holds the sequencer.
module camera_dead_zone_follow
   import cdzf_pkg::*;
#(
   parameter int SCREEN_HALF_W = 160,
   parameter int SCREEN_HALF_H = 120
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_operation,
   input  logic signed [POS_W-1:0] req_target_x,
   input  logic signed [POS_W-1:0] req_target_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [POS_W-1:0] rsp_camera_x,
   output logic signed [POS_W-1:0] rsp_camera_y,
   output logic                    rsp_moved,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   logic        mode_ff;
   logic [15:0] zoom_ff, radius_ff;
   logic [16:0] lerp_ff;
   logic [9:0]  off_x_ff, off_y_ff;
   logic [10:0] width_ff, height_ff;
   logic [10:0] w_eff, h_eff;
   cfg_type     cfg;
   cmd_type     cmd;
   status_type  status;

   // Always ready; the user must write only while idle; the block does not check it.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         zoom_ff   <= 16'd4096;
         radius_ff <= '0;
         lerp_ff   <= LERP_ONE;
         off_x_ff  <= '0;
         off_y_ff  <= '0;
         width_ff  <= 11'd320;
         height_ff <= 11'd240;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MODE:   mode_ff   <= csr_data[0];
            CSR_ZOOM:   zoom_ff   <= csr_data[15:0];
            CSR_RADIUS: radius_ff <= csr_data[15:0];
            CSR_LERP:   lerp_ff   <= csr_data;
            CSR_OFF_X:  off_x_ff  <= csr_data[9:0];
            CSR_OFF_Y:  off_y_ff  <= csr_data[9:0];
            CSR_WIDTH:  width_ff  <= csr_data[10:0];
            CSR_HEIGHT: height_ff <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   // Out-of-range settings are clamped here: zoom to its minimum, an empty
   // viewport to one pixel and lerp to one.
   assign w_eff = (width_ff  == '0) ? 11'd1 : width_ff;
   assign h_eff = (height_ff == '0) ? 11'd1 : height_ff;

   always_comb begin
      cfg.mode   = mode_ff;
      cfg.zoom   = (zoom_ff < MIN_ZOOM) ? MIN_ZOOM : zoom_ff;
      cfg.radius = radius_ff;
      cfg.lerp   = (lerp_ff > LERP_ONE) ? LERP_ONE : lerp_ff;
      cfg.width  = w_eff;
      cfg.height = h_eff;
      // Viewport centre relative to the screen centre, in screen pixels.
      cfg.pcx = $signed({2'b0, off_x_ff}) + $signed({2'b0, w_eff[10:1]})
              - PC_W'(SCREEN_HALF_W);
      cfg.pcy = $signed({2'b0, off_y_ff}) + $signed({2'b0, h_eff[10:1]})
              - PC_W'(SCREEN_HALF_H);
   end

   cdzf_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_operation(req_operation), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .mode(mode_ff), .status(status), .cmd(cmd)
   );

   cdzf_dp u_dp (
      .clock(clock), .reset(reset), .cfg(cfg), .cmd(cmd), .status(status),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .rsp_camera_x(rsp_camera_x), .rsp_camera_y(rsp_camera_y), .rsp_moved(rsp_moved)
   );

endmodule

[rtl/cdzf_div.sv]
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module cdzf_div
   import cdzf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] quo_ff;
   logic [31:0] rem_ff;
   logic [31:0] dvs_ff;
   logic [32:0] rem_sh;
   logic        ge;

   assign rem_sh = {rem_ff, quo_ff[63]};
   assign ge     = (rem_sh >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? 32'(rem_sh - {1'b0, dvs_ff}) : rem_sh[31:0];
         quo_ff <= {quo_ff[62:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/cdzf_sqrt.sv]
// Integer square root of a 64-bit value, two radicand bits per cycle.
module cdzf_sqrt
   import cdzf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] v_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= value;
         res_ff <= '0;
         bit_ff <= 64'd1 << 62;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

[rtl/cdzf_dp.sv]
// Datapath: working registers, shared multiplier, divider and square root unit.
module cdzf_dp
   import cdzf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic signed [POS_W-1:0] req_target_x,
   input  logic signed [POS_W-1:0] req_target_y,
   output logic signed [POS_W-1:0] rsp_camera_x,
   output logic signed [POS_W-1:0] rsp_camera_y,
   output logic                    rsp_moved
);

   logic signed [POS_W-1:0] tx_ff, ty_ff, px_ff, py_ff, nx_ff, ny_ff;
   logic signed [POS_W-1:0] out_x_ff, out_y_ff;
   logic                    out_moved_ff;
   logic signed [POS_W:0]   offx_ff, offy_ff;
   logic [31:0]             r_ff, dxm_ff, dym_ff, ax_ff, dist_ff, e_ff;
   logic                    dxn_ff, dyn_ff, mxn_ff, myn_ff;
   logic [63:0]             prod_ff, acc_ff;
   logic [TMP_W-1:0]        tmp_ff;
   logic [MAG_W-1:0]        mxm_ff, mym_ff, lxm_ff, lym_ff;

   logic        div_start, div_done, sqrt_start, sqrt_done, mul_en;
   logic [63:0] div_dvd, quo;
   logic [31:0] div_dvs, root, mul_a, mul_b;
   logic [10:0] pcx_mag, pcy_mag;
   logic signed [34:0] dfx, dfy;
   logic [32:0] satx, saty;
   logic [31:0] sx_lim;
   logic [47:0] hx;
   logic [44:0] lsum;
   logic signed [45:0] ux, uy;

   function automatic logic [32:0] sat_mag(input logic signed [34:0] v);
      logic [32:0] r;
      if (v > 35'sd2147483647)       r = {1'b0, 32'h7FFF_FFFF};
      else if (v < -35'sd2147483648) r = {1'b1, 32'h8000_0000};
      else if (v < 0)                r = {1'b1, 32'(-v)};
      else                           r = {1'b0, v[31:0]};
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] sat32(input logic signed [45:0] v);
      logic signed [POS_W-1:0] r;
      if (v > 46'sd2147483647)       r = 32'sh7FFF_FFFF;
      else if (v < -46'sd2147483648) r = 32'sh8000_0000;
      else                           r = v[31:0];
      return r;
   endfunction

   cdzf_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dvd),
      .divisor(div_dvs), .done(div_done), .quotient(quo)
   );

   cdzf_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .value(acc_ff),
      .done(sqrt_done), .root(root)
   );

   assign pcx_mag = cfg.pcx[PC_W-1] ? 11'(-cfg.pcx) : cfg.pcx[10:0];
   assign pcy_mag = cfg.pcy[PC_W-1] ? 11'(-cfg.pcy) : cfg.pcy[10:0];
   assign dfx  = 35'(tx_ff) - 35'(offx_ff) - 35'(px_ff);
   assign dfy  = 35'(ty_ff) - 35'(offy_ff) - 35'(py_ff);
   assign satx = sat_mag(dfx);
   assign saty = sat_mag(dfy);
   // A negative scaled x may reach 2^31, a positive one stops at 2^31 - 1.
   assign sx_lim = dxn_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
   assign hx   = quo[47:0];
   // Low partial product sits in tmp, high partial product in prod.
   assign lsum = {prod_ff[28:0], 16'b0} + 45'(tmp_ff[TMP_W-1:16]);
   assign ux   = 46'(px_ff) + (mxn_ff ? -$signed({2'b0, lxm_ff}) : $signed({2'b0, lxm_ff}));
   assign uy   = 46'(py_ff) + (myn_ff ? -$signed({2'b0, lym_ff}) : $signed({2'b0, lym_ff}));

   assign status.unit_done = div_done | sqrt_done;
   assign status.outside   = (acc_ff > prod_ff);

   always_comb begin
      div_start  = 1'b0;
      div_dvd    = '0;
      div_dvs    = '0;
      sqrt_start = 1'b0;
      mul_en     = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      case (cmd.op)
         OP_DIV_OFFX: begin
            div_start = 1'b1;
            div_dvd   = 64'(pcx_mag) << OFF_SHIFT;
            div_dvs   = 32'(cfg.zoom);
         end
         OP_DIV_OFFY: begin
            div_start = 1'b1;
            div_dvd   = 64'(pcy_mag) << OFF_SHIFT;
            div_dvs   = 32'(cfg.zoom);
         end
         OP_DIV_R: begin
            div_start = 1'b1;
            div_dvd   = 64'(cfg.radius) << RAD_SHIFT;
            div_dvs   = 32'(cfg.zoom);
         end
         OP_MUL_DXH: begin mul_en = 1'b1; mul_a = dxm_ff; mul_b = 32'(cfg.height); end
         OP_DIV_SX: begin
            div_start = 1'b1;
            div_dvd   = prod_ff;
            div_dvs   = 32'(cfg.width);
         end
         OP_MUL_AX2: begin mul_en = 1'b1; mul_a = ax_ff;  mul_b = ax_ff;  end
         OP_MUL_AY2: begin mul_en = 1'b1; mul_a = dym_ff; mul_b = dym_ff; end
         OP_MUL_R2:  begin mul_en = 1'b1; mul_a = r_ff;   mul_b = r_ff;   end
         OP_SQRT:    sqrt_start = 1'b1;
         OP_MUL_AXE: begin mul_en = 1'b1; mul_a = ax_ff; mul_b = e_ff; end
         OP_DIV_Q1: begin
            div_start = 1'b1;
            div_dvd   = prod_ff;
            div_dvs   = dist_ff;
         end
         OP_MUL_QW: begin mul_en = 1'b1; mul_a = quo[31:0]; mul_b = 32'(cfg.width); end
         OP_DIV_MX: begin
            div_start = 1'b1;
            div_dvd   = prod_ff;
            div_dvs   = 32'(cfg.height);
         end
         OP_MUL_AYE: begin mul_en = 1'b1; mul_a = dym_ff; mul_b = e_ff; end
         OP_DIV_MY: begin
            div_start = 1'b1;
            div_dvd   = prod_ff;
            div_dvs   = dist_ff;
         end
         OP_MUL_RW: begin mul_en = 1'b1; mul_a = 32'(cfg.radius); mul_b = 32'(cfg.width); end
         OP_MUL_HZ: begin mul_en = 1'b1; mul_a = 32'(cfg.height); mul_b = 32'(cfg.zoom); end
         OP_DIV_HX: begin
            div_start = 1'b1;
            div_dvd   = 64'(tmp_ff[26:0]) << RAD_SHIFT;
            div_dvs   = prod_ff[31:0];
         end
         OP_MUL_LXL: begin mul_en = 1'b1; mul_a = mxm_ff[31:0]; mul_b = 32'(cfg.lerp); end
         OP_MUL_LXH: begin
            mul_en = 1'b1; mul_a = 32'(mxm_ff[MAG_W-1:32]); mul_b = 32'(cfg.lerp);
         end
         OP_MUL_LYL: begin mul_en = 1'b1; mul_a = mym_ff[31:0]; mul_b = 32'(cfg.lerp); end
         OP_MUL_LYH: begin
            mul_en = 1'b1; mul_a = 32'(mym_ff[MAG_W-1:32]); mul_b = 32'(cfg.lerp);
         end
         default: ;
      endcase
   end

   // Camera position is architectural state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
      end else if (cmd.op == OP_PUBLISH) begin
         px_ff <= nx_ff;
         py_ff <= ny_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) prod_ff <= mul_a * mul_b;
      case (cmd.op)
         OP_LOAD: begin
            tx_ff <= req_target_x;
            ty_ff <= req_target_y;
         end
         OP_SET: begin
            nx_ff <= tx_ff;
            ny_ff <= ty_ff;
         end
         OP_GET_OFFX: offx_ff <= cfg.pcx[PC_W-1] ? -$signed({1'b0, quo[31:0]})
                                                 :  $signed({1'b0, quo[31:0]});
         OP_GET_OFFY: offy_ff <= cfg.pcy[PC_W-1] ? -$signed({1'b0, quo[31:0]})
                                                 :  $signed({1'b0, quo[31:0]});
         OP_GET_R: r_ff <= quo[31:0];
         OP_DELTA: begin
            {dxn_ff, dxm_ff} <= satx;
            {dyn_ff, dym_ff} <= saty;
         end
         OP_GET_SX: ax_ff <= (quo > 64'(sx_lim)) ? sx_lim : quo[31:0];
         OP_MUL_AY2: acc_ff <= prod_ff;
         OP_MUL_R2:  acc_ff <= acc_ff + prod_ff;
         OP_GET_DIST: begin
            dist_ff <= root;
            e_ff    <= root - r_ff;
         end
         OP_GET_MX: begin
            mxm_ff <= quo[MAG_W-1:0];
            mxn_ff <= dxn_ff;
         end
         OP_GET_MY: begin
            mym_ff <= quo[MAG_W-1:0];
            myn_ff <= dyn_ff;
         end
         OP_ZERO_M: begin
            mxm_ff <= '0;
            mym_ff <= '0;
            mxn_ff <= 1'b0;
            myn_ff <= 1'b0;
         end
         OP_MUL_HZ:  tmp_ff <= prod_ff[TMP_W-1:0];
         OP_GET_RECT: begin
            mxm_ff <= ({16'b0, dxm_ff} > hx) ? MAG_W'(dxm_ff - hx[31:0]) : '0;
            mym_ff <= (dym_ff > r_ff) ? MAG_W'(dym_ff - r_ff) : '0;
            mxn_ff <= dxn_ff;
            myn_ff <= dyn_ff;
         end
         OP_MUL_LXH: tmp_ff <= prod_ff[TMP_W-1:0];
         OP_GET_LX:  lxm_ff <= lsum[MAG_W-1:0];
         OP_MUL_LYH: tmp_ff <= prod_ff[TMP_W-1:0];
         OP_GET_LY:  lym_ff <= lsum[MAG_W-1:0];
         OP_UPDATE: begin
            nx_ff <= sat32(ux);
            ny_ff <= sat32(uy);
         end
         OP_PUBLISH: begin
            out_x_ff     <= nx_ff;
            out_y_ff     <= ny_ff;
            out_moved_ff <= (nx_ff != px_ff) || (ny_ff != py_ff);
         end
         default: ;
      endcase
   end

   assign rsp_camera_x = out_x_ff;
   assign rsp_camera_y = out_y_ff;
   assign rsp_moved    = out_moved_ff;

endmodule

[rtl/cdzf_ctrl.sv]
// Sequencer: steps the datapath through one word and runs both handshakes.
module cdzf_ctrl
   import cdzf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_operation,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       mode,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [5:0] ST_IDLE  = 6'd0;
   localparam logic [5:0] ST_WAIT  = 6'd1;
   localparam logic [5:0] ST_SET   = 6'd2;
   localparam logic [5:0] ST_OFFX  = 6'd3;
   localparam logic [5:0] ST_GOFFX = 6'd4;
   localparam logic [5:0] ST_OFFY  = 6'd5;
   localparam logic [5:0] ST_GOFFY = 6'd6;
   localparam logic [5:0] ST_R     = 6'd7;
   localparam logic [5:0] ST_GR    = 6'd8;
   localparam logic [5:0] ST_DELTA = 6'd9;
   localparam logic [5:0] ST_DXH   = 6'd10;
   localparam logic [5:0] ST_SX    = 6'd11;
   localparam logic [5:0] ST_GSX   = 6'd12;
   localparam logic [5:0] ST_AX2   = 6'd13;
   localparam logic [5:0] ST_AY2   = 6'd14;
   localparam logic [5:0] ST_R2    = 6'd15;
   localparam logic [5:0] ST_CMP   = 6'd16;
   localparam logic [5:0] ST_ZERO  = 6'd17;
   localparam logic [5:0] ST_SQRT  = 6'd18;
   localparam logic [5:0] ST_GDIST = 6'd19;
   localparam logic [5:0] ST_AXE   = 6'd20;
   localparam logic [5:0] ST_Q1    = 6'd21;
   localparam logic [5:0] ST_QW    = 6'd22;
   localparam logic [5:0] ST_MX    = 6'd23;
   localparam logic [5:0] ST_GMX   = 6'd24;
   localparam logic [5:0] ST_AYE   = 6'd25;
   localparam logic [5:0] ST_MY    = 6'd26;
   localparam logic [5:0] ST_GMY   = 6'd27;
   localparam logic [5:0] ST_RW    = 6'd28;
   localparam logic [5:0] ST_HZ    = 6'd29;
   localparam logic [5:0] ST_HX    = 6'd30;
   localparam logic [5:0] ST_GHX   = 6'd31;
   localparam logic [5:0] ST_LXL   = 6'd32;
   localparam logic [5:0] ST_LXH   = 6'd33;
   localparam logic [5:0] ST_GLX   = 6'd34;
   localparam logic [5:0] ST_LYL   = 6'd35;
   localparam logic [5:0] ST_LYH   = 6'd36;
   localparam logic [5:0] ST_GLY   = 6'd37;
   localparam logic [5:0] ST_UPD   = 6'd38;
   localparam logic [5:0] ST_OUT   = 6'd39;

   logic [5:0] state_ff, state_in, ret_ff, ret_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_blocked;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd.op   = OP_NOP;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.op   = OP_LOAD;
            state_in = req_operation ? ST_SET : ST_OFFX;
         end
         ST_WAIT:  if (status.unit_done) state_in = ret_ff;
         ST_SET:   begin cmd.op = OP_SET;      state_in = ST_OUT;   end
         ST_OFFX:  begin cmd.op = OP_DIV_OFFX; state_in = ST_WAIT; ret_in = ST_GOFFX; end
         ST_GOFFX: begin cmd.op = OP_GET_OFFX; state_in = ST_OFFY;  end
         ST_OFFY:  begin cmd.op = OP_DIV_OFFY; state_in = ST_WAIT; ret_in = ST_GOFFY; end
         ST_GOFFY: begin cmd.op = OP_GET_OFFY; state_in = ST_R;     end
         ST_R:     begin cmd.op = OP_DIV_R;    state_in = ST_WAIT; ret_in = ST_GR; end
         ST_GR:    begin cmd.op = OP_GET_R;    state_in = ST_DELTA; end
         ST_DELTA: begin cmd.op = OP_DELTA;    state_in = mode ? ST_RW : ST_DXH; end
         ST_DXH:   begin cmd.op = OP_MUL_DXH;  state_in = ST_SX;    end
         ST_SX:    begin cmd.op = OP_DIV_SX;   state_in = ST_WAIT; ret_in = ST_GSX; end
         ST_GSX:   begin cmd.op = OP_GET_SX;   state_in = ST_AX2;   end
         ST_AX2:   begin cmd.op = OP_MUL_AX2;  state_in = ST_AY2;   end
         ST_AY2:   begin cmd.op = OP_MUL_AY2;  state_in = ST_R2;    end
         ST_R2:    begin cmd.op = OP_MUL_R2;   state_in = ST_CMP;   end
         ST_CMP:   state_in = status.outside ? ST_SQRT : ST_ZERO;
         ST_ZERO:  begin cmd.op = OP_ZERO_M;   state_in = ST_LXL;   end
         ST_SQRT:  begin cmd.op = OP_SQRT;     state_in = ST_WAIT; ret_in = ST_GDIST; end
         ST_GDIST: begin cmd.op = OP_GET_DIST; state_in = ST_AXE;   end
         ST_AXE:   begin cmd.op = OP_MUL_AXE;  state_in = ST_Q1;    end
         ST_Q1:    begin cmd.op = OP_DIV_Q1;   state_in = ST_WAIT; ret_in = ST_QW; end
         ST_QW:    begin cmd.op = OP_MUL_QW;   state_in = ST_MX;    end
         ST_MX:    begin cmd.op = OP_DIV_MX;   state_in = ST_WAIT; ret_in = ST_GMX; end
         ST_GMX:   begin cmd.op = OP_GET_MX;   state_in = ST_AYE;   end
         ST_AYE:   begin cmd.op = OP_MUL_AYE;  state_in = ST_MY;    end
         ST_MY:    begin cmd.op = OP_DIV_MY;   state_in = ST_WAIT; ret_in = ST_GMY; end
         ST_GMY:   begin cmd.op = OP_GET_MY;   state_in = ST_LXL;   end
         ST_RW:    begin cmd.op = OP_MUL_RW;   state_in = ST_HZ;    end
         ST_HZ:    begin cmd.op = OP_MUL_HZ;   state_in = ST_HX;    end
         ST_HX:    begin cmd.op = OP_DIV_HX;   state_in = ST_WAIT; ret_in = ST_GHX; end
         ST_GHX:   begin cmd.op = OP_GET_RECT; state_in = ST_LXL;   end
         ST_LXL:   begin cmd.op = OP_MUL_LXL;  state_in = ST_LXH;   end
         ST_LXH:   begin cmd.op = OP_MUL_LXH;  state_in = ST_GLX;   end
         ST_GLX:   begin cmd.op = OP_GET_LX;   state_in = ST_LYL;   end
         ST_LYL:   begin cmd.op = OP_MUL_LYL;  state_in = ST_LYH;   end
         ST_LYH:   begin cmd.op = OP_MUL_LYH;  state_in = ST_GLY;   end
         ST_GLY:   begin cmd.op = OP_GET_LY;   state_in = ST_UPD;   end
         ST_UPD:   begin cmd.op = OP_UPDATE;   state_in = ST_OUT;   end
         ST_OUT: if (!out_blocked) begin
            cmd.op   = OP_PUBLISH;
            state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.op == OP_PUBLISH)       rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[tb/tb_camera_dead_zone_follow.sv]
// Self-checking testbench for the camera dead-zone follow block.
`timescale 1ns / 100ps

module tb_camera_dead_zone_follow;
   import cdzf_pkg::*;

   // One input word of the follow channel.
   typedef struct {
      logic            op;
      logic [31:0]     tx;
      logic [31:0]     ty;
   } target_word_type;

   // One result word: camera position after the step and the moved flag.
   typedef struct {
      logic [31:0]     cx;
      logic [31:0]     cy;
      logic            moved;
   } camera_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_operation = 1'b0;
   logic signed [POS_W-1:0] req_target_x = '0;
   logic signed [POS_W-1:0] req_target_y = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_camera_x;
   logic signed [POS_W-1:0] rsp_camera_y;
   logic                    rsp_moved;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   camera_dead_zone_follow u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_target_x  (req_target_x),
      .req_target_y  (req_target_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_camera_x  (rsp_camera_x),
      .rsp_camera_y  (rsp_camera_y),
      .rsp_moved     (rsp_moved),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pending target words waiting for the driver, and predicted camera words
   // waiting for the monitor.
   target_word_type target_pending[$];
   camera_word_type camera_expected[$];

   // Shadow copy of the register file and of the camera position.
   logic        sh_mode = 1'b0;
   logic [15:0] sh_zoom = 16'd4096;
   logic [15:0] sh_radius = '0;
   logic [16:0] sh_lerp = 17'd65536;
   logic [9:0]  sh_off_x = '0;
   logic [9:0]  sh_off_y = '0;
   logic [10:0] sh_width = 11'd320;
   logic [10:0] sh_height = 11'd240;
   longint      cam_x = 0;
   longint      cam_y = 0;

   bit idle_en = 1'b1;     // random idling on both channels
   bit hold_on = 1'b0;     // long receiver hold-off
   bit failed = 1'b0;

   localparam longint SCREEN_HALF_W_TB = 160;
   localparam longint SCREEN_HALF_H_TB = 120;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Truncating a * num / den, done on magnitudes like the hardware does.
   function automatic longint muldiv_tz(longint a, longint unsigned num,
                                        longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = (a < 0) ? 64'd0 - longint'(a) : a;
      q = (mag * num) / den;
      return (a < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Advances the shadow camera by one word and returns the camera word
   // the block must produce for it.
   function automatic camera_word_type follow_step(target_word_type w);
      camera_word_type r;
      longint          tx, ty, nx, ny, offx, offy, dx, dy, rad, mx, my, sx, hx;
      longint unsigned z, wd, ht, lp, ax, ay, dsq, rsq, rlen, e;
      tx = longint'($signed(w.tx));
      ty = longint'($signed(w.ty));
      nx = cam_x;
      ny = cam_y;
      if (w.op) begin
         nx = tx;
         ny = ty;
      end else begin
         z  = (sh_zoom < MIN_ZOOM) ? MIN_ZOOM : sh_zoom;
         wd = (sh_width == 0) ? 1 : sh_width;
         ht = (sh_height == 0) ? 1 : sh_height;
         lp = (sh_lerp > LERP_ONE) ? LERP_ONE : sh_lerp;
         offx = muldiv_tz(longint'(sh_off_x) + longint'(wd / 2) - SCREEN_HALF_W_TB,
                          64'd1 << OFF_SHIFT, z);
         offy = muldiv_tz(longint'(sh_off_y) + longint'(ht / 2) - SCREEN_HALF_H_TB,
                          64'd1 << OFF_SHIFT, z);
         dx  = clamp32(tx - offx - cam_x);
         dy  = clamp32(ty - offy - cam_y);
         rad = longint'((longint'(sh_radius) << RAD_SHIFT) / z);
         mx  = 0;
         my  = 0;
         if (sh_mode == 1'b0) begin
            // Elliptical zone: squash x by the aspect ratio, then pull the
            // target back onto the ellipse along the ray from the center.
            sx  = clamp32(muldiv_tz(dx, ht, wd));
            ax  = (sx < 0) ? -sx : sx;
            ay  = (dy < 0) ? -dy : dy;
            dsq = ax * ax + ay * ay;
            rsq = rad * rad;
            if (dsq > rsq) begin
               rlen = int_sqrt(dsq);
               e  = rlen - rad;
               mx = muldiv_tz(muldiv_tz(sx, e, rlen), wd, ht);
               my = muldiv_tz(dy, e, rlen);
            end
         end else begin
            hx = longint'((longint'(sh_radius) * wd << RAD_SHIFT) / (ht * z));
            if (dx > hx) mx = dx - hx;
            else if (dx < -hx) mx = dx + hx;
            if (dy > rad) my = dy - rad;
            else if (dy < -rad) my = dy + rad;
         end
         nx = clamp32(cam_x + muldiv_tz(mx, lp, 64'd65536));
         ny = clamp32(cam_y + muldiv_tz(my, lp, 64'd65536));
      end
      r.moved = (nx != cam_x) || (ny != cam_y);
      cam_x = nx;
      cam_y = ny;
      r.cx = nx[31:0];
      r.cy = ny[31:0];
      return r;
   endfunction

   // Driver: presents the oldest pending word and predicts its result once
   // the block takes it. A stalled word is held unchanged.
   always @(posedge clock) begin
      bit took;
      took = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (took) begin
            camera_expected.push_back(follow_step(target_pending.pop_front()));
         end
         if (!req_valid || took) begin
            if (target_pending.size() > 0 &&
                !(idle_en && $urandom_range(99) < 29)) begin
               req_valid     <= 1'b1;
               req_operation <= target_pending[0].op;
               req_target_x  <= target_pending[0].tx;
               req_target_y  <= target_pending[0].ty;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every accepted result word against the oldest
   // prediction and drives the stall of the result channel.
   always @(posedge clock) begin
      camera_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (camera_expected.size() == 0) begin
               $display("%0t: unexpected result word x=%h y=%h moved=%b", $time,
                        rsp_camera_x, rsp_camera_y, rsp_moved);
               failed = 1'b1;
            end else begin
               want = camera_expected.pop_front();
               if (rsp_camera_x !== want.cx) begin
                  $display("%0t: camera_x expected %h actual %h", $time, want.cx,
                           rsp_camera_x);
                  failed = 1'b1;
               end
               if (rsp_camera_y !== want.cy) begin
                  $display("%0t: camera_y expected %h actual %h", $time, want.cy,
                           rsp_camera_y);
                  failed = 1'b1;
               end
               if (rsp_moved !== want.moved) begin
                  $display("%0t: moved expected %b actual %b", $time, want.moved,
                           rsp_moved);
                  failed = 1'b1;
               end
            end
         end
         rsp_stall <= hold_on || (idle_en && $urandom_range(99) < 29);
      end
   end

   // Writes one register through the CSR channel and mirrors it in the shadow.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:   sh_mode   = val[0];
         CSR_ZOOM:   sh_zoom   = val[15:0];
         CSR_RADIUS: sh_radius = val[15:0];
         CSR_LERP:   sh_lerp   = val[16:0];
         CSR_OFF_X:  sh_off_x  = val[9:0];
         CSR_OFF_Y:  sh_off_y  = val[9:0];
         CSR_WIDTH:  sh_width  = val[10:0];
         CSR_HEIGHT: sh_height = val[10:0];
         default: ;
      endcase
   endtask

   task automatic write_all(logic mode, logic [15:0] zm, logic [15:0] rad,
                            logic [16:0] lp, logic [9:0] ox, logic [9:0] oy,
                            logic [10:0] wd, logic [10:0] ht);
      csr_write(CSR_MODE, mode);
      csr_write(CSR_ZOOM, zm);
      csr_write(CSR_RADIUS, rad);
      csr_write(CSR_LERP, lp);
      csr_write(CSR_OFF_X, ox);
      csr_write(CSR_OFF_Y, oy);
      csr_write(CSR_WIDTH, wd);
      csr_write(CSR_HEIGHT, ht);
   endtask

   // The sender pauses here until every predicted word has come back.
   task automatic drain;
      while (target_pending.size() != 0 || camera_expected.size() != 0 || req_valid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic queue_word(logic op, logic [31:0] tx, logic [31:0] ty);
      target_word_type w;
      w.op = op;
      w.tx = tx;
      w.ty = ty;
      target_pending.push_back(w);
   endtask

   // Random words. Most targets sit near the camera so that both sides of the
   // dead-zone boundary are hit; the rest span the whole coordinate range.
   // The camera used for "near" is the last one predicted before the batch is
   // queued, so every word of a batch is placed around that same position.
   task automatic queue_random(int count);
      logic [31:0] base_x, base_y, spread;
      for (int i = 0; i < count; i++) begin
         base_x = cam_x[31:0];
         base_y = cam_y[31:0];
         spread = 32'd1 << $urandom_range(8, 26);
         case ($urandom_range(9))
            0, 1, 2: queue_word(1'b1, $urandom, $urandom);
            3:       queue_word(1'b0, $urandom, $urandom);
            default: queue_word(1'b0,
                                base_x + $urandom_range(spread) - spread / 2,
                                base_y + $urandom_range(spread) - spread / 2);
         endcase
      end
   endtask

   // Long hold-off on the result side while the sender keeps offering words,
   // so the block fills up and stalls its input.
   initial begin
      wait (!reset);
      repeat (3000) @(posedge clock);
      hold_on <= 1'b1;
      repeat (4000) @(posedge clock);
      hold_on <= 1'b0;
   end

   initial begin
      #40ms;
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words with the reset register values: position loads at the
      // extremes, an unchanged load, and follows on both sides of the zone.
      queue_word(1'b1, 32'h7fff_ffff, 32'h8000_0000);
      queue_word(1'b1, 32'h7fff_ffff, 32'h8000_0000);
      queue_word(1'b0, 32'h7fff_ffff, 32'h8000_0000);
      queue_word(1'b0, 32'h8000_0000, 32'h7fff_ffff);
      queue_word(1'b1, 32'h0, 32'h0);
      queue_word(1'b0, 32'h0, 32'h0);
      queue_word(1'b0, 32'h0001_0000, 32'hffff_0000);
      queue_word(1'b0, 32'hffff_ffff, 32'hffff_ffff);
      drain();

      // Radius, lerp above one and a rectangle zone with saturating sums.
      write_all(1'b1, 16'd4096, 16'h0a00, 17'h1ffff, 10'd0, 10'd0, 11'd320, 11'd240);
      queue_word(1'b1, 32'h7fff_0000, 32'h8001_0000);
      queue_word(1'b0, 32'h7fff_ffff, 32'h8000_0000);
      queue_word(1'b0, 32'h7fff_0000, 32'h8001_0000);
      queue_word(1'b0, 32'h8000_0000, 32'h7fff_ffff);
      drain();

      // Zoom below its minimum and zero viewport size, ellipse zone.
      write_all(1'b0, 16'd0, 16'hffff, 17'd0, 10'd1023, 10'd1023, 11'd0, 11'd0);
      queue_word(1'b0, 32'h1234_5678, 32'h8765_4321);
      drain();
      csr_write(CSR_LERP, 17'd32768);
      queue_word(1'b0, 32'h1234_5678, 32'h8765_4321);
      queue_word(1'b0, 32'h7fff_ffff, 32'h7fff_ffff);
      queue_word(1'b0, 32'h8000_0000, 32'h8000_0000);
      drain();

      // Widest viewport, largest zoom and offsets at opposite extremes, then rectangle mode.
      write_all(1'b0, 16'hffff, 16'd1, 17'd65536, 10'd0, 10'd1023, 11'd2047, 11'd1);
      queue_word(1'b0, 32'h0100_0000, 32'hff00_0000);
      queue_word(1'b0, 32'h8000_0000, 32'h7fff_ffff);
      drain();
      csr_write(CSR_MODE, 1'b1);
      queue_word(1'b0, 32'h7fff_ffff, 32'h8000_0000);
      queue_word(1'b0, 32'h0, 32'h0);
      drain();

      // Random phases, each with fresh registers. One phase runs without any idling.
      for (int ph = 0; ph < 10; ph++) begin
         idle_en = (ph != 5);
         if (ph % 3 == 0)
            write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
         else
            write_all($urandom, $urandom_range(205, 16384), $urandom_range(4096),
                      $urandom_range(65536), $urandom_range(1023),
                      $urandom_range(1023), $urandom_range(1, 1024),
                      $urandom_range(1, 1024));
         queue_random(160);
         drain();
      end

      repeat (50) @(posedge clock);
      if (!failed) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/cdzf_pkg.sv
rtl/cdzf_div.sv
rtl/cdzf_sqrt.sv
rtl/cdzf_dp.sv
rtl/cdzf_ctrl.sv
rtl/camera_dead_zone_follow.sv
tb/tb_camera_dead_zone_follow.sv
